@@ sv/lbd_pkg.sv @@
// lbd_pkg: shared types and codes for the lattice birth/death/mutation step.
// Holds cell codes, mode and event codes, register indexes, the Moore table and sequencer states.
// No dependencies.
package lbd_pkg;

	// lattice cell codes
	localparam logic [1:0] CELL_EMPTY = 2'd0;
	localparam logic [1:0] CELL_WILD  = 2'd1;
	localparam logic [1:0] CELL_MUT   = 2'd2;

	// item modes
	localparam logic [1:0] MODE_EVENT   = 2'd0;
	localparam logic [1:0] MODE_RESTART = 2'd1;
	localparam logic [1:0] MODE_TREAT   = 2'd2;
	localparam logic [1:0] MODE_SPARE   = 2'd3;

	// event kinds reported in a result beat
	localparam logic [2:0] KIND_NONE    = 3'd0;
	localparam logic [2:0] KIND_DEATH   = 3'd1;
	localparam logic [2:0] KIND_BIRTH   = 3'd2;
	localparam logic [2:0] KIND_MUTATED = 3'd3;
	localparam logic [2:0] KIND_BLOCKED = 3'd4;

	// configuration register indexes
	localparam logic [2:0] REG_WILD_DEATH  = 3'd0;
	localparam logic [2:0] REG_WILD_DIVIDE = 3'd1;
	localparam logic [2:0] REG_MUT_DEATH   = 3'd2;
	localparam logic [2:0] REG_MUT_DIVIDE  = 3'd3;
	localparam logic [2:0] REG_MUTATION    = 3'd4;
	localparam logic [2:0] REG_TARGET      = 3'd5;
	localparam logic [2:0] REG_UNUSED      = 3'd7;

	localparam logic [16:0] TARGET_RESET = 17'h10000;

	// Moore neighbor offsets, indexed by direction
	localparam logic signed [1:0] MOORE_DR [8] = '{
		2'sd1, 2'sd1, 2'sd1, 2'sd0, 2'sd0, -2'sd1, -2'sd1, -2'sd1};
	localparam logic signed [1:0] MOORE_DC [8] = '{
		2'sd1, 2'sd0, -2'sd1, 2'sd1, -2'sd1, 2'sd1, 2'sd0, -2'sd1};

	// sequencer states, one-hot
	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_CLR    = 9'b000000010,
		ST_EV_L   = 9'b000000100,
		ST_EV_T   = 9'b000001000,
		ST_EV_N   = 9'b000010000,
		ST_TR_RD  = 9'b000100000,
		ST_TR_POS = 9'b001000000,
		ST_TR_TYP = 9'b010000000,
		ST_FIN    = 9'b100000000
	} state_t;

endpackage

@@ sv/lattice_birth_death_mutation_step.sv @@
// lattice_birth_death_mutation_step: periodic lattice birth/death/mutation engine.
// Uses lbd_pkg for codes and lbd_ram for the lattice and occupied-list memories.
//
//  channel | signals                               | direction
//  --------+---------------------------------------+----------
//  in      | in_valid, in_stall, mode .. mut draw  | item in
//  out     | out_valid, out_stall, population ..   | result out
//  cfg     | cfg_we, cfg_index, cfg_data           | register write
//
// Event item: out of range goes straight to the result; else list and cell reads, and a neighbor read on division.
// Restart item: a sweep of all GRID_SIDE*GRID_SIDE sites of the lattice memory.
// Treatment item: walks the occupied list, reading, locating and typing each occupied site.
// After reset a clearing pass over all GRID_SIDE*GRID_SIDE sites runs; in_stall is high.
// One item at a time; in_stall is high outside idle. A held result beat waits in
// the output register while the next item is worked on.
module lattice_birth_death_mutation_step
	import lbd_pkg::*;
#(
	parameter int GRID_SIDE = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [32:0] cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [15:0] site_index,
	input  logic [31:0] event_draw,
	input  logic [2:0]  direction,
	input  logic [31:0] mutation_draw,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [16:0] population,
	output logic [16:0] wild_total,
	output logic [16:0] mutant_total,
	output logic [2:0]  event_kind,
	output logic [7:0]  site_row,
	output logic [7:0]  site_col,
	output logic        status,
	output logic        target_reached
);

	localparam int SITES  = GRID_SIDE * GRID_SIDE;
	localparam int RC_W   = $clog2(GRID_SIDE);
	localparam int ADDR_W = $clog2(SITES);
	localparam int CNT_W  = $clog2(SITES + 1);
	localparam int LE_W   = 2 * RC_W;
	localparam logic [ADDR_W-1:0] SIDE_A   = ADDR_W'(GRID_SIDE);
	localparam logic [RC_W-1:0]   CTR_RC   = RC_W'(GRID_SIDE / 2);
	localparam logic [ADDR_W-1:0] CTR_ADDR = ADDR_W'((GRID_SIDE / 2) * GRID_SIDE + GRID_SIDE / 2);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(SITES - 1);
	localparam logic [CNT_W-1:0]  SITES_C  = CNT_W'(SITES);

	// row*side+col address of a site
	function automatic logic [ADDR_W-1:0] site_addr(input logic [RC_W-1:0] r,
		input logic [RC_W-1:0] c);
		site_addr = ADDR_W'(r) * SIDE_A + ADDR_W'(c);
	endfunction

	// one periodic step along an axis
	function automatic logic [RC_W-1:0] wrap_step(input logic [RC_W-1:0] v,
		input logic signed [1:0] d);
		if (d > 2'sd0) begin
			wrap_step = (v == RC_W'(GRID_SIDE - 1)) ? '0 : v + 1'b1;
		end else if (d < 2'sd0) begin
			wrap_step = (v == '0) ? RC_W'(GRID_SIDE - 1) : v - 1'b1;
		end else begin
			wrap_step = v;
		end
	endfunction

	state_t state_q;

	// configuration registers
	logic [32:0] wd_lim_q, wb_lim_q, md_lim_q, mb_lim_q, mut_lim_q;
	logic [16:0] target_q;

	// counts
	logic [CNT_W-1:0] pop_q, wild_q, mut_q, kept_q;
	logic [ADDR_W-1:0] cnt_q;
	logic rep_q;

	// item working registers
	logic [ADDR_W-1:0] idx_q;
	logic [31:0] draw_q, mdraw_q;
	logic [2:0] dir_q;
	logic [RC_W-1:0] r0_q, c0_q, nr_q, nc_q;
	logic [LE_W-1:0] pos_q;
	logic par_wild_q;
	logic [2:0] kind_q;
	logic [RC_W-1:0] row_q, col_q;
	logic status_q;

	// output registers
	logic out_valid_q;
	logic [16:0] pop_out_q, wild_out_q, mut_out_q;
	logic [2:0] kind_out_q;
	logic [7:0] row_out_q, col_out_q;
	logic status_out_q, tgt_out_q;

	// memory ports
	logic lat_we, list_we;
	logic [ADDR_W-1:0] lat_waddr, lat_raddr, list_waddr, list_raddr;
	logic [1:0] lat_wdata, lat_rdata;
	logic [LE_W-1:0] list_wdata, list_rdata;

	lbd_ram #(.WIDTH(2), .DEPTH(SITES)) u_lattice (
		.clk(clk), .we(lat_we), .waddr(lat_waddr), .wdata(lat_wdata),
		.raddr(lat_raddr), .rdata(lat_rdata));

	lbd_ram #(.WIDTH(LE_W), .DEPTH(SITES)) u_list (
		.clk(clk), .we(list_we), .waddr(list_waddr), .wdata(list_wdata),
		.raddr(list_raddr), .rdata(list_rdata));

	logic in_acc, out_load;
	logic idx_bad;
	logic [RC_W-1:0] le_r, le_c, le_nr, le_nc;
	logic cell_wild, do_death, do_divide;
	logic [32:0] dlim, blim;
	logic nbr_free, mutate;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_load = (state_q == ST_FIN) && (!out_valid_q || !out_stall);
	assign idx_bad  = 32'(site_index) >= 32'(pop_q);

	// list entry split and cell decisions
	assign le_r      = pos_q[LE_W-1:RC_W];
	assign le_c      = pos_q[RC_W-1:0];
	assign cell_wild = (lat_rdata == CELL_WILD);
	assign dlim      = cell_wild ? wd_lim_q : md_lim_q;
	assign blim      = cell_wild ? wb_lim_q : mb_lim_q;
	assign do_death  = {1'b0, draw_q} < dlim;
	assign do_divide = {1'b0, draw_q} < blim;
	assign le_nr     = wrap_step(r0_q, MOORE_DR[dir_q]);
	assign le_nc     = wrap_step(c0_q, MOORE_DC[dir_q]);
	assign nbr_free  = (lat_rdata == CELL_EMPTY) && (pop_q < SITES_C);
	assign mutate    = par_wild_q && ({1'b0, mdraw_q} < mut_lim_q);

	// memory address and write control
	always_comb begin
		lat_we     = 1'b0;
		lat_waddr  = cnt_q;
		lat_wdata  = CELL_EMPTY;
		lat_raddr  = site_addr(r0_q, c0_q);
		list_we    = 1'b0;
		list_waddr = '0;
		list_wdata = {CTR_RC, CTR_RC};
		list_raddr = cnt_q;
		case (state_q)
			ST_IDLE: begin
				list_raddr = ADDR_W'(site_index);
			end
			ST_CLR: begin
				lat_we    = 1'b1;
				lat_wdata = (cnt_q == CTR_ADDR) ? CELL_WILD : CELL_EMPTY;
				list_we   = (cnt_q == '0);
			end
			ST_EV_L: begin
				lat_raddr  = site_addr(list_rdata[LE_W-1:RC_W], list_rdata[RC_W-1:0]);
				list_raddr = ADDR_W'(pop_q - 1'b1);
			end
			ST_EV_T: begin
				lat_raddr = site_addr(le_nr, le_nc);
				if (do_death) begin
					lat_we     = 1'b1;
					lat_waddr  = site_addr(r0_q, c0_q);
					list_we    = 1'b1;
					list_waddr = idx_q;
					list_wdata = list_rdata;
				end
			end
			ST_EV_N: begin
				if (nbr_free) begin
					lat_we     = 1'b1;
					lat_waddr  = site_addr(nr_q, nc_q);
					lat_wdata  = (par_wild_q && !mutate) ? CELL_WILD : CELL_MUT;
					list_we    = 1'b1;
					list_waddr = ADDR_W'(pop_q);
					list_wdata = {nr_q, nc_q};
				end
			end
			ST_TR_POS: begin
				lat_raddr = site_addr(list_rdata[LE_W-1:RC_W], list_rdata[RC_W-1:0]);
			end
			ST_TR_TYP: begin
				if (lat_rdata == CELL_MUT) begin
					list_we    = 1'b1;
					list_waddr = ADDR_W'(kept_q);
					list_wdata = pos_q;
				end else begin
					lat_we    = 1'b1;
					lat_waddr = site_addr(le_r, le_c);
				end
			end
			default: begin
			end
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wd_lim_q  <= '0;
			wb_lim_q  <= '0;
			md_lim_q  <= '0;
			mb_lim_q  <= '0;
			mut_lim_q <= '0;
			target_q  <= TARGET_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WILD_DEATH:  wd_lim_q  <= cfg_data;
				REG_WILD_DIVIDE: wb_lim_q  <= cfg_data;
				REG_MUT_DEATH:   md_lim_q  <= cfg_data;
				REG_MUT_DIVIDE:  mb_lim_q  <= cfg_data;
				REG_MUTATION:    mut_lim_q <= cfg_data;
				REG_TARGET:      target_q  <= cfg_data[16:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			cnt_q   <= '0;
			rep_q   <= 1'b0;
			pop_q   <= CNT_W'(1);
			wild_q  <= CNT_W'(1);
			mut_q   <= '0;
			kept_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (mode)
							MODE_EVENT: begin
								state_q <= idx_bad ? ST_FIN : ST_EV_L;
							end
							MODE_RESTART: begin
								cnt_q   <= '0;
								rep_q   <= 1'b1;
								state_q <= ST_CLR;
							end
							MODE_TREAT: begin
								cnt_q  <= '0;
								kept_q <= '0;
								if (pop_q == '0) begin
									wild_q  <= '0;
									mut_q   <= '0;
									state_q <= ST_FIN;
								end else begin
									state_q <= ST_TR_RD;
								end
							end
							default: state_q <= ST_FIN;
						endcase
					end
				end
				ST_CLR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_ADDR) begin
						pop_q   <= CNT_W'(1);
						wild_q  <= CNT_W'(1);
						mut_q   <= '0;
						state_q <= rep_q ? ST_FIN : ST_IDLE;
					end
				end
				ST_EV_L: state_q <= ST_EV_T;
				ST_EV_T: begin
					if (do_death) begin
						pop_q <= pop_q - 1'b1;
						if (cell_wild) begin
							if (wild_q != '0) wild_q <= wild_q - 1'b1;
						end else begin
							if (mut_q != '0) mut_q <= mut_q - 1'b1;
						end
						state_q <= ST_FIN;
					end else if (do_divide) begin
						state_q <= ST_EV_N;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_EV_N: begin
					if (nbr_free) begin
						pop_q <= pop_q + 1'b1;
						if (par_wild_q && !mutate) wild_q <= wild_q + 1'b1;
						else mut_q <= mut_q + 1'b1;
					end
					state_q <= ST_FIN;
				end
				ST_TR_RD:  state_q <= ST_TR_POS;
				ST_TR_POS: state_q <= ST_TR_TYP;
				ST_TR_TYP: begin
					if (CNT_W'(cnt_q) + 1'b1 == pop_q) begin
						pop_q   <= kept_q + ((lat_rdata == CELL_MUT) ? 1'b1 : 1'b0);
						mut_q   <= kept_q + ((lat_rdata == CELL_MUT) ? 1'b1 : 1'b0);
						wild_q  <= '0;
						state_q <= ST_FIN;
					end else begin
						if (lat_rdata == CELL_MUT) kept_q <= kept_q + 1'b1;
						cnt_q   <= cnt_q + 1'b1;
						state_q <= ST_TR_RD;
					end
				end
				ST_FIN: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				idx_q    <= ADDR_W'(site_index);
				draw_q   <= event_draw;
				mdraw_q  <= mutation_draw;
				dir_q    <= direction;
				kind_q   <= KIND_NONE;
				row_q    <= '0;
				col_q    <= '0;
				status_q <= (mode == MODE_EVENT) && idx_bad;
			end
			ST_EV_L: begin
				r0_q <= list_rdata[LE_W-1:RC_W];
				c0_q <= list_rdata[RC_W-1:0];
			end
			ST_EV_T: begin
				par_wild_q <= cell_wild;
				nr_q       <= le_nr;
				nc_q       <= le_nc;
				if (do_death) begin
					kind_q <= KIND_DEATH;
					row_q  <= r0_q;
					col_q  <= c0_q;
				end
			end
			ST_EV_N: begin
				if (nbr_free) begin
					kind_q <= mutate ? KIND_MUTATED : KIND_BIRTH;
					row_q  <= nr_q;
					col_q  <= nc_q;
				end else begin
					kind_q <= KIND_BLOCKED;
				end
			end
			ST_TR_POS: pos_q <= list_rdata;
			default: begin
			end
		endcase
	end

	// result beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pop_out_q    <= 17'(pop_q);
			wild_out_q   <= 17'(wild_q);
			mut_out_q    <= 17'(mut_q);
			kind_out_q   <= kind_q;
			row_out_q    <= 8'(row_q);
			col_out_q    <= 8'(col_q);
			status_out_q <= status_q;
			tgt_out_q    <= 32'(pop_q) >= 32'(target_q);
		end
	end

	assign out_valid      = out_valid_q;
	assign population     = pop_out_q;
	assign wild_total     = wild_out_q;
	assign mutant_total   = mut_out_q;
	assign event_kind     = kind_out_q;
	assign site_row       = row_out_q;
	assign site_col       = col_out_q;
	assign status         = status_out_q;
	assign target_reached = tgt_out_q;

endmodule

@@ sv/lbd_ram.sv @@
// lbd_ram: generic single-write, single-read synchronous RAM.
// Read data is registered. No dependencies.
module lbd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ bench/tb.sv @@
// tb: self-checking bench for lattice_birth_death_mutation_step.
// Drives random and directed event, restart, treatment and spare beats, predicts each result
// beat from a private copy of the lattice and occupied list; depends on lbd_pkg.
`timescale 1ns / 100ps

module tb;
	import lbd_pkg::*;

	typedef struct packed {
		logic [16:0] pop;
		logic [16:0] wild;
		logic [16:0] mut;
		logic [2:0]  kind;
		logic [7:0]  row;
		logic [7:0]  col;
		logic        stat;
		logic        reached;
	} step_result_t;

	// Predicts step results and matches them against the result beats
	class lattice_scoreboard;
		bit [1:0]  grid [65536];
		bit [15:0] roster [65536];
		bit [16:0] pop_cnt, wild_cnt, mut_cnt;
		bit [32:0] wild_death, wild_divide, mut_death, mut_divide, mut_thresh;
		bit [16:0] target;
		step_result_t pending[$];
		int errors, checked, deaths, births, mutated, blocked, treats, restarts;

		function new();
			wild_death = 0; wild_divide = 0; mut_death = 0; mut_divide = 0;
			mut_thresh = 0; target = TARGET_RESET;
			seed_center();
		endfunction

		function void seed_center();
			foreach (grid[i]) grid[i] = CELL_EMPTY;
			grid[16'h8080] = CELL_WILD;
			roster[0] = 16'h8080;
			pop_cnt = 1; wild_cnt = 1; mut_cnt = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [32:0] val);
			case (idx)
				REG_WILD_DEATH:  wild_death = val;
				REG_WILD_DIVIDE: wild_divide = val;
				REG_MUT_DEATH:   mut_death = val;
				REG_MUT_DIVIDE:  mut_divide = val;
				REG_MUTATION:    mut_thresh = val;
				REG_TARGET:      target = val[16:0];
				default: ;
			endcase
		endfunction

		// accepted input beat: update state, queue the expected result
		function void note(logic [1:0] md, logic [15:0] idx, logic [31:0] draw,
				logic [2:0] dir, logic [31:0] mdraw);
			step_result_t r;
			bit [15:0] pos, npos;
			bit [7:0] nr, nc;
			bit is_wild, mutate;
			bit [32:0] dlim, blim;
			r = '0;
			if (md == MODE_RESTART) begin
				seed_center();
				restarts++;
			end else if (md == MODE_TREAT) begin
				bit [16:0] kept;
				kept = 0;
				for (int i = 0; i < pop_cnt; i++) begin
					pos = roster[i];
					if (grid[pos] == CELL_MUT) begin
						roster[kept] = pos;
						kept++;
					end else grid[pos] = CELL_EMPTY;
				end
				pop_cnt = kept; wild_cnt = 0; mut_cnt = kept;
				treats++;
			end else if (md == MODE_EVENT) begin
				if (idx >= pop_cnt) r.stat = 1'b1;
				else begin
					pos = roster[idx];
					is_wild = (grid[pos] == CELL_WILD);
					dlim = is_wild ? wild_death : mut_death;
					blim = is_wild ? wild_divide : mut_divide;
					if ({1'b0, draw} < dlim) begin
						grid[pos] = CELL_EMPTY;
						pop_cnt--;
						if (is_wild) begin
							if (wild_cnt != 0) wild_cnt--;
						end else if (mut_cnt != 0) mut_cnt--;
						roster[idx] = roster[pop_cnt];
						r.kind = KIND_DEATH; r.row = pos[15:8]; r.col = pos[7:0];
						deaths++;
					end else if ({1'b0, draw} < blim) begin
						nr = pos[15:8] + {{6{MOORE_DR[dir][1]}}, MOORE_DR[dir]};
						nc = pos[7:0] + {{6{MOORE_DC[dir][1]}}, MOORE_DC[dir]};
						npos = {nr, nc};
						if (grid[npos] != CELL_EMPTY || pop_cnt >= 17'h10000) begin
							r.kind = KIND_BLOCKED;
							blocked++;
						end else begin
							mutate = is_wild && ({1'b0, mdraw} < mut_thresh);
							grid[npos] = (is_wild && !mutate) ? CELL_WILD : CELL_MUT;
							roster[pop_cnt] = npos;
							pop_cnt++;
							if (is_wild && !mutate) wild_cnt++;
							else mut_cnt++;
							r.kind = mutate ? KIND_MUTATED : KIND_BIRTH;
							r.row = nr; r.col = nc;
							if (mutate) mutated++;
							else births++;
						end
					end
				end
			end
			r.pop = pop_cnt; r.wild = wild_cnt; r.mut = mut_cnt;
			r.reached = (pop_cnt >= target);
			pending = {pending, r};
		endfunction

		function void cmp(string name, logic [16:0] exp, logic [16:0] act);
			if (exp !== act) begin
				$display("%0t mismatch %s: expected %0d, actual %0d", $time, name, exp, act);
				errors++;
			end
		endfunction

		function void check(step_result_t got);
			step_result_t e;
			checked++;
			if (pending.size() == 0) begin
				$display("%0t unexpected result beat: expected none, actual %h", $time, got);
				errors++;
				return;
			end
			e = pending.pop_front();
			cmp("population", e.pop, got.pop);
			cmp("wild_total", e.wild, got.wild);
			cmp("mutant_total", e.mut, got.mut);
			cmp("event_kind", e.kind, got.kind);
			cmp("site_row", e.row, got.row);
			cmp("site_col", e.col, got.col);
			cmp("status", e.stat, got.stat);
			cmp("target_reached", e.reached, got.reached);
		endfunction
	endclass

	logic        clk, arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [32:0] cfg_data;
	logic        in_valid, in_stall;
	logic [1:0]  mode;
	logic [15:0] site_index;
	logic [31:0] event_draw, mutation_draw;
	logic [2:0]  direction;
	logic        out_valid, out_stall;
	logic [16:0] population, wild_total, mutant_total;
	logic [2:0]  event_kind;
	logic [7:0]  site_row, site_col;
	logic        status, target_reached;

	int send_idle, recv_idle;
	lattice_scoreboard sb = new();

	lattice_birth_death_mutation_step u_dut (.*);

	always begin
		clk = 1'b0; #10;
		clk = 1'b1; #10;
	end

	// result side: check accepted beats, stall at random
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check('{population, wild_total, mutant_total, event_kind,
				site_row, site_col, status, target_reached});
		out_stall <= ($urandom_range(99) < recv_idle);
	end

	initial begin
		#40_000_000;
		$display("FAIL lattice_birth_death_mutation_step");
		$finish;
	end

	task automatic send_beat(logic [1:0] md, logic [15:0] idx, logic [31:0] draw,
			logic [2:0] dir, logic [31:0] mdraw);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= md; site_index <= idx; event_draw <= draw;
		direction <= dir; mutation_draw <= mdraw;
		do @(posedge clk); while (in_stall);
		sb.note(md, idx, draw, dir, mdraw);
	endtask

	// hold the input side until every expected beat is back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [32:0] val);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic set_rates(logic [32:0] wd, logic [32:0] wv, logic [32:0] md,
			logic [32:0] mv, logic [32:0] mt, logic [32:0] tg);
		write_reg(REG_WILD_DEATH, wd);
		write_reg(REG_WILD_DIVIDE, wv);
		write_reg(REG_MUT_DEATH, md);
		write_reg(REG_MUT_DIVIDE, mv);
		write_reg(REG_MUTATION, mt);
		write_reg(REG_TARGET, tg);
	endtask

	task automatic random_phase(int n);
		int r;
		send_beat(MODE_RESTART, 16'($urandom), $urandom, 3'($urandom), $urandom);
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 2 && sb.mut_cnt > 3)
				send_beat(MODE_TREAT, 16'($urandom), $urandom, 3'($urandom), $urandom);
			else if (r == 2)
				send_beat(MODE_SPARE, 16'($urandom), $urandom, 3'($urandom), $urandom);
			else if (r < 9 || sb.pop_cnt == 0)
				send_beat(MODE_EVENT, 16'($urandom), $urandom, 3'($urandom), $urandom);
			else
				send_beat(MODE_EVENT, 16'($urandom_range(sb.pop_cnt - 1)), $urandom,
					3'($urandom), $urandom);
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		in_valid = 1'b0; mode = MODE_EVENT; site_index = '0;
		event_draw = '0; direction = '0; mutation_draw = '0;
		out_stall = 1'b0;
		send_idle = 38; recv_idle = 61;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset limits, every event is a no-event or out of range
		send_beat(MODE_EVENT, 16'd0, 32'd0, 3'd0, 32'd0);
		send_beat(MODE_EVENT, 16'd1, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF);
		send_beat(MODE_EVENT, 16'hFFFF, 32'd0, 3'd0, 32'd0);
		drain();
		// everything divides, half of wild divisions mutate
		set_rates(33'd0, 33'h1_0000_0000, 33'd0, 33'h1_0000_0000, 33'h0_8000_0000, 33'd2);
		write_reg(REG_UNUSED, 33'h1_FFFF_FFFF);
		send_beat(MODE_EVENT, 16'd0, 32'hFFFF_FFFF, 3'd0, 32'hFFFF_FFFF);
		send_beat(MODE_EVENT, 16'd0, 32'd0, 3'd0, 32'd0);
		for (int d = 1; d < 8; d++)
			send_beat(MODE_EVENT, 16'd0, 32'h1234_5678, 3'(d),
				d[0] ? 32'd0 : 32'h8000_0000);
		send_beat(MODE_EVENT, 16'd2, 32'd0, 3'd5, 32'd0);
		send_beat(MODE_SPARE, 16'hFFFF, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF);
		send_beat(MODE_TREAT, 16'd0, 32'd0, 3'd0, 32'd0);
		drain();
		// everything dies, target of zero always reached
		set_rates(33'h1_0000_0000, 33'h1_0000_0000, 33'h1_0000_0000, 33'd0, 33'd0, 33'd0);
		send_beat(MODE_EVENT, 16'd0, 32'hFFFF_FFFF, 3'd0, 32'd0);
		send_beat(MODE_EVENT, 16'(sb.pop_cnt - 1), 32'd0, 3'd0, 32'd0);
		send_beat(MODE_EVENT, 16'd0, 32'h8000_0000, 3'd3, 32'd0);
		send_beat(MODE_RESTART, 16'd0, 32'd0, 3'd0, 32'd0);
		send_beat(MODE_EVENT, 16'd0, 32'hFFFF_FFFF, 3'd0, 32'd0);
		drain();

		// random: growth-leaning rates per phase
		set_rates(33'h0_2000_0000, 33'h0_A000_0000, 33'h0_3000_0000, 33'h0_B000_0000,
			33'h0_4000_0000, 33'd300);
		random_phase(200);
		send_idle = 61; recv_idle = 38;
		set_rates(33'h0_5000_0000, 33'h0_9000_0000, 33'h0_1000_0000, 33'h1_0000_0000,
			33'h1_0000_0000, 33'h1_0000);
		random_phase(200);
		send_idle = 0; recv_idle = 0;
		set_rates(33'h0_3000_0000, 33'h0_C000_0000, 33'd0, 33'h0_8000_0000, 33'd0, 33'd1);
		random_phase(200);

		$display("checked %0d result beats: %0d deaths, %0d births, %0d mutated births,",
			sb.checked, sb.deaths, sb.births, sb.mutated);
		$display("%0d blocked divisions, %0d treatments, %0d restarts",
			sb.blocked, sb.treats, sb.restarts);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("PASS lattice_birth_death_mutation_step");
		else
			$display("FAIL lattice_birth_death_mutation_step");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/lbd_pkg.sv
sv/lbd_ram.sv
sv/lattice_birth_death_mutation_step.sv
bench/tb.sv
